/* rtl/core/sgr_pkg.sv */
// Shared types, constants and the SGR code decoder of the console attribute parser.
package sgr_pkg;

    // Parse modes
    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_ESC    = 2'd1;
    localparam logic [1:0] MODE_CSI    = 2'd2;

    // Bytes of interest
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_M      = 8'h6D;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // Attribute bits
    localparam logic [6:0] FG_ALL   = 7'h07;
    localparam logic [6:0] FG_INT   = 7'h08;
    localparam logic [6:0] BG_ALL   = 7'h70;
    localparam logic [6:0] ATTR_RST = 7'h07;

    // SGR codes
    localparam logic [7:0] SGR_RESET      = 8'd0;
    localparam logic [7:0] SGR_BOLD       = 8'd1;
    localparam logic [7:0] SGR_DIM        = 8'd2;
    localparam logic [7:0] SGR_HIDE       = 8'd8;
    localparam logic [7:0] SGR_FG_BASE    = 8'd30;
    localparam logic [7:0] SGR_FG_CYAN    = 8'd36;
    localparam logic [7:0] SGR_FG_WHITE   = 8'd37;
    localparam logic [7:0] SGR_FG_DEFAULT = 8'd39;
    localparam logic [7:0] SGR_BG_BASE    = 8'd40;
    localparam logic [7:0] SGR_BG_RED     = 8'd41;
    localparam logic [7:0] SGR_BG_CYAN    = 8'd46;
    localparam logic [7:0] SGR_BG_WHITE   = 8'd47;
    localparam logic [7:0] SGR_BG_DEFAULT = 8'd49;

    // Result kinds
    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_ATTR = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // Command bodies passed from front to back
    localparam logic [2:0] BODY_NONE = 3'd0;
    localparam logic [2:0] BODY_CHAR = 3'd1;
    localparam logic [2:0] BODY_ATTR = 3'd2;
    localparam logic [2:0] BODY_ERR  = 3'd3;
    localparam logic [2:0] BODY_NL   = 3'd4;

    // Queue geometry (both queues)
    localparam int QDEPTH = 4;
    localparam int QIDX_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Config register indexes
    localparam logic CFG_SILENT    = 1'b0;
    localparam logic CFG_INIT_ATTR = 1'b1;

    typedef struct packed {
        logic       pre_esc;
        logic [2:0] body;
        logic [7:0] ch;
        logic [6:0] attr1;
        logic [6:0] attr2;
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
        logic [6:0] attr;
        logic       last;
    } res_t;

    // ANSI colour index to R=4,G=2,B=1: a bit reversal
    function automatic logic [2:0] ansi_to_rgb(input logic [2:0] idx);
        return {idx[0], idx[1], idx[2]};
    endfunction

    function automatic logic [6:0] apply_code(input logic [6:0] a, input logic [7:0] code);
        logic [6:0] r;
        logic [7:0] fg_off;
        logic [7:0] bg_off;
        r      = a;
        fg_off = code - SGR_FG_BASE;
        bg_off = code - SGR_BG_BASE;
        case (code)
            SGR_RESET:                      r = ATTR_RST;
            SGR_BOLD:                       r = a | FG_INT;
            SGR_DIM:                        r = (a & ~FG_ALL) | FG_INT;
            SGR_HIDE:                       r = '0;
            SGR_FG_WHITE, SGR_FG_DEFAULT:   r = a | FG_ALL;
            SGR_BG_BASE, SGR_BG_DEFAULT:    r = a & ~BG_ALL;
            SGR_BG_WHITE:                   r = a | BG_ALL;
            default:
            begin
                if (code inside {[SGR_FG_BASE:SGR_FG_CYAN]})
                begin
                    r = {a[6:3], ansi_to_rgb(fg_off[2:0])};
                end
                else if (code inside {[SGR_BG_RED:SGR_BG_CYAN]})
                begin
                    r = {ansi_to_rgb(bg_off[2:0]), a[3:0]};
                end
            end
        endcase
        return r;
    endfunction

endpackage

/* rtl/core/ansi_sgr_console_attribute_parser_top.sv */
// Top level of the ANSI SGR console attribute parser.
//
// Channel   Direction  Handshake            Payload
// -------   ---------  -------------------  ---------------------------------------
// text in   in         push / full          text_byte
// results   out        pop / empty          kind, char_value, attribute, last
// config    in         cfg_write (no wait)  cfg_index, cfg_data
//
// A byte is taken every cycle while full is low; the front parses it in the
// cycle it arrives and drops at most one command into a four-entry command
// queue. The back expands a command into one result beat per cycle (up to
// five for ESC then newline) into a four-entry result queue, stalling while
// that queue is full; input stalls only once the command queue fills.
// Reset (rst_n, asynchronous) returns normal mode, a zero code and attribute 7,
// and empties both queues. Either side may stall for any length of time.
module ansi_sgr_console_attribute_parser_top
    import sgr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // configuration
    input  logic       cfg_write,
    input  logic       cfg_index,
    input  logic [6:0] cfg_data,
    // text beats in
    input  logic       push,
    output logic       full,
    input  logic [7:0] text_byte,
    // result beats out
    input  logic       pop,
    output logic       empty,
    output logic [1:0] kind,
    output logic [7:0] char_value,
    output logic [6:0] attribute,
    output logic       last
);

    logic cmd_valid;
    cmd_t cmd_in;
    logic cq_full;
    logic cq_empty;
    logic cq_pop;
    cmd_t cq_head;

    // Input stalls only on a full command queue; silent bytes are consumed too.
    assign full = cq_full;

    sgr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .text_byte (text_byte),
        .q_full    (cq_full),
        .cmd_valid (cmd_valid),
        .cmd       (cmd_in)
    );

    sgr_cmdq u_cmdq (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (cmd_valid),
        .wr_cmd (cmd_in),
        .full   (cq_full),
        .rd_en  (cq_pop),
        .empty  (cq_empty),
        .rd_cmd (cq_head)
    );

    sgr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cq_empty   (cq_empty),
        .cq_cmd     (cq_head),
        .cq_pop     (cq_pop),
        .pop        (pop),
        .empty      (empty),
        .kind       (kind),
        .char_value (char_value),
        .attribute  (attribute),
        .last       (last)
    );

endmodule

/* rtl/core/sgr_cmdq.sv */
// Command queue between the parsing front and the expanding back.
module sgr_cmdq
    import sgr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_cmd,
    output logic full,
    input  logic rd_en,
    output logic empty,
    output cmd_t rd_cmd
);

    cmd_t              mem_reg [QDEPTH];
    logic [QIDX_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QIDX_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              do_wr, do_rd;

    assign full   = (cnt_reg == QCNT_W'(QDEPTH));
    assign empty  = (cnt_reg == '0);
    assign rd_cmd = mem_reg[rd_ptr_reg];
    assign do_wr  = wr_en && !full;
    assign do_rd  = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!do_wr && do_rd)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

/* rtl/core/sgr_front.sv */
// Parse front: mode, code accumulator and attribute state; at most one command per byte.
module sgr_front
    import sgr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic       cfg_index,
    input  logic [6:0] cfg_data,
    input  logic       push,
    input  logic [7:0] text_byte,
    input  logic       q_full,
    output logic       cmd_valid,
    output cmd_t       cmd
);

    logic [1:0] mode_reg, mode_next;
    logic [7:0] acc_reg, acc_next;
    logic [6:0] cur_reg, cur_next;
    logic [6:0] init_reg;
    logic       silent_reg;

    logic       take;
    logic       is_digit;
    logic [3:0] digit;
    logic [11:0] acc_sum;
    logic [6:0] new_attr;

    assign take     = push && !q_full && !silent_reg;
    assign is_digit = (text_byte inside {[CH_ZERO:CH_NINE]});
    assign digit    = 4'(text_byte - CH_ZERO);
    assign acc_sum  = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} + {8'd0, digit};
    assign new_attr = apply_code(cur_reg, acc_reg);

    // Plain-text handling shared by normal mode and the ESC fall-through
    function automatic void normal_byte(
        input  logic [7:0] b,
        input  logic [6:0] init_a,
        input  logic [6:0] cur_a,
        inout  cmd_t       c,
        inout  logic [1:0] m
    );
        m = MODE_NORMAL;
        if (b == CH_NL)
        begin
            c.body  = BODY_NL;
            c.attr1 = init_a;
            c.attr2 = cur_a;
        end
        else if (b == CH_ESC)
        begin
            m = MODE_ESC;
        end
        else
        begin
            c.body = BODY_CHAR;
            c.ch   = b;
        end
    endfunction

    always_comb
    begin
        mode_next   = mode_reg;
        acc_next    = acc_reg;
        cur_next    = cur_reg;
        cmd.pre_esc = 1'b0;
        cmd.body    = BODY_NONE;
        cmd.ch      = text_byte;
        cmd.attr1   = '0;
        cmd.attr2   = '0;
        case (mode_reg)
            MODE_ESC:
            begin
                if (text_byte == CH_LBRACK)
                begin
                    mode_next = MODE_CSI;
                    acc_next  = '0;
                end
                else
                begin
                    cmd.pre_esc = 1'b1;
                    normal_byte(text_byte, init_reg, cur_reg, cmd, mode_next);
                end
            end
            MODE_CSI:
            begin
                if (is_digit)
                begin
                    acc_next = (acc_sum > 12'd255) ? 8'hFF : acc_sum[7:0];
                end
                else if (text_byte == CH_SEMI || text_byte == CH_M)
                begin
                    cur_next  = new_attr;
                    acc_next  = '0;
                    cmd.body  = BODY_ATTR;
                    cmd.attr1 = new_attr;
                    if (text_byte == CH_M)
                    begin
                        mode_next = MODE_NORMAL;
                    end
                end
                else
                begin
                    acc_next  = '0;
                    mode_next = MODE_NORMAL;
                    cmd.body  = BODY_ERR;
                end
            end
            default:
            begin
                normal_byte(text_byte, init_reg, cur_reg, cmd, mode_next);
            end
        endcase
    end

    assign cmd_valid = take && (cmd.pre_esc || cmd.body != BODY_NONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_NORMAL;
            acc_reg    <= '0;
            cur_reg    <= ATTR_RST;
            init_reg   <= ATTR_RST;
            silent_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            if (cfg_index == CFG_SILENT)
            begin
                silent_reg <= cfg_data[0];
            end
            else
            begin
                init_reg <= cfg_data;
                cur_reg  <= cfg_data;
            end
        end
        else if (take)
        begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            cur_reg  <= cur_next;
        end
    end

endmodule

/* rtl/core/sgr_back.sv */
// Expansion back: turns each command into its result beats and queues them.
module sgr_back
    import sgr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cq_empty,
    input  cmd_t       cq_cmd,
    output logic       cq_pop,
    input  logic       pop,
    output logic       empty,
    output logic [1:0] kind,
    output logic [7:0] char_value,
    output logic [6:0] attribute,
    output logic       last
);

    res_t              mem_reg [QDEPTH];
    logic [QIDX_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic [2:0]        step_reg;

    logic       rq_full;
    logic       gen;
    logic       do_rd;
    logic [2:0] body_len;
    logic [2:0] total;
    logic [2:0] j;
    res_t       res;

    assign rq_full = (cnt_reg == QCNT_W'(QDEPTH));
    assign empty   = (cnt_reg == '0);
    assign gen     = !cq_empty && !rq_full;
    assign do_rd   = pop && !empty;

    always_comb
    begin
        case (cq_cmd.body)
            BODY_CHAR, BODY_ATTR, BODY_ERR: body_len = 3'd1;
            BODY_NL:                        body_len = 3'd4;
            default:                        body_len = 3'd0;
        endcase
        total = body_len + {2'b00, cq_cmd.pre_esc};
        j     = step_reg - {2'b00, cq_cmd.pre_esc};

        res.kind = KIND_CHAR;
        res.ch   = '0;
        res.attr = '0;
        res.last = (step_reg == total - 3'd1);
        if (cq_cmd.pre_esc && step_reg == 3'd0)
        begin
            res.ch = CH_ESC;
        end
        else
        begin
            case (cq_cmd.body)
                BODY_CHAR:
                begin
                    res.ch = cq_cmd.ch;
                end
                BODY_ATTR:
                begin
                    res.kind = KIND_ATTR;
                    res.attr = cq_cmd.attr1;
                end
                BODY_ERR:
                begin
                    res.kind = KIND_ERR;
                    res.ch   = cq_cmd.ch;
                end
                BODY_NL:
                begin
                    case (j)
                        3'd0:
                        begin
                            res.kind = KIND_ATTR;
                            res.attr = cq_cmd.attr1;
                        end
                        3'd1:    res.ch = CH_CR;
                        3'd2:    res.ch = CH_NL;
                        default:
                        begin
                            res.kind = KIND_ATTR;
                            res.attr = cq_cmd.attr2;
                        end
                    endcase
                end
                default:
                begin
                    res.ch = '0;
                end
            endcase
        end
    end

    assign cq_pop = gen && res.last;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (gen && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!gen && do_rd)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
            step_reg   <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (gen)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
                step_reg   <= res.last ? 3'd0 : step_reg + 3'd1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (gen)
        begin
            mem_reg[wr_ptr_reg] <= res;
        end
    end

    assign kind       = mem_reg[rd_ptr_reg].kind;
    assign char_value = mem_reg[rd_ptr_reg].ch;
    assign attribute  = mem_reg[rd_ptr_reg].attr;
    assign last       = mem_reg[rd_ptr_reg].last;

endmodule

/* verif/sgr_console_checker.sv */
// Watches the text and result channels of the SGR parser, predicts every result beat and checks it.
module sgr_console_checker
    import sgr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic       cfg_index,
    input  logic [6:0] cfg_data,
    input  logic       push,
    input  logic       full,
    input  logic [7:0] text_byte,
    input  logic       pop,
    input  logic       empty,
    input  logic [1:0] kind,
    input  logic [7:0] char_value,
    input  logic [6:0] attribute,
    input  logic       last,
    output int         errors,
    output int         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // ANSI colour index to R=4,G=2,B=1
    localparam logic [2:0] RGB_OF [0:7] = '{3'd0, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7};

    logic       silent;
    logic [6:0] home_attr;
    logic [1:0] mode;
    logic [7:0] code_acc;
    logic [6:0] cur_attr;

    res_t console_beats[$];   // expected result beats, oldest first
    res_t step_beats[$];      // beats caused by the byte being predicted

    function automatic logic [6:0] recolour(input logic [6:0] a, input logic [7:0] code);
        logic [6:0] r;
        logic [7:0] idx;
        r = a;
        case (code)
            SGR_RESET:                    r = ATTR_RST;
            SGR_BOLD:                     r = a | FG_INT;
            SGR_DIM:                      r = (a & ~FG_ALL) | FG_INT;
            SGR_HIDE:                     r = 7'd0;
            SGR_FG_WHITE, SGR_FG_DEFAULT: r = a | FG_ALL;
            SGR_BG_BASE, SGR_BG_DEFAULT:  r = a & ~BG_ALL;
            SGR_BG_WHITE:                 r = a | BG_ALL;
            default:
            begin
                if (code >= SGR_FG_BASE && code <= SGR_FG_CYAN)
                begin
                    idx = code - SGR_FG_BASE;
                    r = (a & ~FG_ALL) | {4'd0, RGB_OF[idx[2:0]]};
                end
                else if (code >= SGR_BG_RED && code <= SGR_BG_CYAN)
                begin
                    idx = code - SGR_BG_BASE;
                    r = (a & ~BG_ALL) | {RGB_OF[idx[2:0]], 4'd0};
                end
            end
        endcase
        return r;
    endfunction

    function automatic void note(input logic [1:0] k, input logic [7:0] ch, input logic [6:0] at);
        res_t r;
        r.kind = k;
        r.ch   = ch;
        r.attr = at;
        r.last = 1'b0;
        step_beats.push_back(r);
    endfunction

    // Byte handling in normal mode, also used after a lone ESC
    task automatic plain_byte(input logic [7:0] b);
        if (b == CH_NL)
        begin
            note(KIND_ATTR, 8'd0, home_attr);
            note(KIND_CHAR, CH_CR, 7'd0);
            note(KIND_CHAR, CH_NL, 7'd0);
            note(KIND_ATTR, 8'd0, cur_attr);
        end
        else if (b == CH_ESC)
            mode = MODE_ESC;
        else
            note(KIND_CHAR, b, 7'd0);
    endtask

    task automatic parse_byte(input logic [7:0] b);
        int acc;
        res_t r;
        if (silent)
            return;
        step_beats.delete();
        if (mode == MODE_ESC)
        begin
            if (b == CH_LBRACK)
            begin
                mode     = MODE_CSI;
                code_acc = 8'd0;
            end
            else
            begin
                mode = MODE_NORMAL;
                note(KIND_CHAR, CH_ESC, 7'd0);
                plain_byte(b);
            end
        end
        else if (mode == MODE_CSI)
        begin
            if (b >= CH_ZERO && b <= CH_NINE)
            begin
                acc      = int'(code_acc) * 10 + int'(b - CH_ZERO);
                code_acc = (acc > 255) ? 8'd255 : acc[7:0];
            end
            else if (b == CH_SEMI || b == CH_M)
            begin
                cur_attr = recolour(cur_attr, code_acc);
                code_acc = 8'd0;
                note(KIND_ATTR, 8'd0, cur_attr);
                if (b == CH_M)
                    mode = MODE_NORMAL;
            end
            else
            begin
                code_acc = 8'd0;
                mode     = MODE_NORMAL;
                note(KIND_ERR, b, 7'd0);
            end
        end
        else
            plain_byte(b);
        if (step_beats.size() > 0)
        begin
            r = step_beats[$];
            r.last = 1'b1;
            step_beats[step_beats.size() - 1] = r;
        end
        foreach (step_beats[i])
            console_beats.push_back(step_beats[i]);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    task automatic check_beat();
        res_t want;
        if (console_beats.size() == 0)
        begin
            errors++;
            $display("%0t ns: unexpected result beat, expected none, got kind %0d char %0d attr %0d",
                     $time, kind, char_value, attribute);
            return;
        end
        want = console_beats.pop_front();
        check_field("kind", int'(want.kind), int'(kind));
        check_field("char_value", int'(want.ch), int'(char_value));
        check_field("attribute", int'(want.attr), int'(attribute));
        check_field("last", int'(want.last), int'(last));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            silent    = 1'b0;
            home_attr = ATTR_RST;
            mode      = MODE_NORMAL;
            code_acc  = 8'd0;
            cur_attr  = ATTR_RST;
            console_beats.delete();
            errors    = 0;
            pending   <= 0;
        end
        else
        begin
            // results first: a beat can never come from a byte taken at the same edge
            if (pop && !empty)
                check_beat();
            if (cfg_write)
            begin
                if (cfg_index == CFG_SILENT)
                    silent = cfg_data[0];
                else if (cfg_index == CFG_INIT_ATTR)
                begin
                    home_attr = cfg_data;
                    cur_attr  = cfg_data;
                end
            end
            if (push && !full)
                parse_byte(text_byte);
            pending <= console_beats.size();
        end
    end

endmodule

/* verif/tb.sv */
// Top of the SGR parser testbench: clock, reset, text stimulus, result drain and verdict.
module tb
    import sgr_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic       clk;
    logic       rst_n;
    logic       cfg_write;
    logic       cfg_index;
    logic [6:0] cfg_data;
    logic       push;
    logic       full;
    logic [7:0] text_byte;
    logic       pop;
    logic       empty;
    logic [1:0] kind;
    logic [7:0] char_value;
    logic [6:0] attribute;
    logic       last;
    int         errors;
    int         pending;

    // Opening bytes: plain, zero and top byte, a newline, a two-code sequence,
    // ESC before an ordinary byte, ESC before a newline, ESC ESC then a
    // saturating code, and a sequence cut by a bad terminator.
    localparam logic [7:0] LEAD_IN [0:24] = '{
        8'h41, 8'h00, 8'hFF, CH_NL,
        CH_ESC, CH_LBRACK, 8'h31, CH_SEMI, 8'h33, 8'h31, CH_M,
        CH_ESC, 8'h78,
        CH_ESC, CH_NL,
        CH_ESC, CH_ESC, CH_LBRACK, 8'h39, 8'h39, 8'h39, CH_M,
        CH_ESC, CH_LBRACK, 8'h7A
    };

    int   burst_left;      // beats left in the current send burst
    int   bytes_taken;     // beats accepted while the block was listening
    bit   silent_now;
    int   hold_requests;   // bumped by the stimulus, served by the receiver
    int   holds_done;

    ansi_sgr_console_attribute_parser_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .full       (full),
        .text_byte  (text_byte),
        .pop        (pop),
        .empty      (empty),
        .kind       (kind),
        .char_value (char_value),
        .attribute  (attribute),
        .last       (last)
    );

    sgr_console_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .full       (full),
        .text_byte  (text_byte),
        .pop        (pop),
        .empty      (empty),
        .kind       (kind),
        .char_value (char_value),
        .attribute  (attribute),
        .last       (last),
        .errors     (errors),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Offer one byte and hold it until the block takes it. Bursts of random
    // length, with a random gap (often none) before each burst.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        push      <= 1'b1;
        text_byte <= b;
        @(posedge clk);
        while (full)
            @(posedge clk);
        if (!silent_now)
            bytes_taken++;
    endtask

    // Decimal code, sometimes with leading zeros
    task automatic send_code(input int v);
        int digits[$];
        repeat ($urandom_range(0, 5) == 0 ? $urandom_range(1, 2) : 0)
            send_byte(CH_ZERO);
        do
        begin
            digits.push_front(v % 10);
            v = v / 10;
        end
        while (v > 0);
        foreach (digits[i])
            send_byte(CH_ZERO + 8'(digits[i]));
    endtask

    task automatic sgr_sequence();
        int n;
        send_byte(CH_ESC);
        send_byte(CH_LBRACK);
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: send_code(SGR_FG_BASE + $urandom_range(0, 9));
                3, 4, 5: send_code(SGR_BG_BASE + $urandom_range(0, 9));
                6:
                begin
                    case ($urandom_range(0, 3))
                        0: send_code(SGR_RESET);
                        1: send_code(SGR_BOLD);
                        2: send_code(SGR_DIM);
                        default: send_code(SGR_HIDE);
                    endcase
                end
                7: send_code($urandom_range(0, 255));
                8: send_code($urandom_range(256, 99999));   // pins the accumulator
                default: ;                                  // empty code acts as reset
            endcase
            if (i < n - 1)
                send_byte(CH_SEMI);
            else if ($urandom_range(0, 7) == 0)
                send_byte(8'($urandom_range(0, 255)));      // broken terminator
            else
                send_byte(CH_M);
        end
    endtask

    task automatic random_unit();
        logic [7:0] b;
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7: sgr_sequence();
            8, 9, 10, 11, 12:
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(8'h20, 8'h7E)));
            13, 14: send_byte(CH_NL);
            15, 16:
            begin
                b = ($urandom_range(0, 3) == 0) ? CH_NL : 8'($urandom_range(0, 255));
                if (b == CH_LBRACK)
                    b = CH_ESC;
                send_byte(CH_ESC);
                send_byte(b);
            end
            default: send_byte(8'($urandom_range(0, 255)));
        endcase
    endtask

    task automatic run_random(input int n);
        int target;
        target = bytes_taken + n;
        while (bytes_taken < target)
            random_unit();
    endtask

    // Stop offering until every predicted beat is out, then let bytes that
    // make no result clear the command path.
    task automatic drain();
        push <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [6:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // Receiver: runs of full-rate, half-rate and starved popping; a hold
    // request forces a long stall so the queues fill and full rises.
    initial
    begin
        int stall_left;
        int span;
        int style;
        stall_left = 0;
        pop <= 1'b0;
        forever
        begin
            style = $urandom_range(0, 2);
            span  = $urandom_range(16, 64);
            repeat (span)
            begin
                @(posedge clk);
                if (hold_requests != holds_done)
                begin
                    holds_done++;
                    stall_left = 300;
                end
                if (stall_left > 0)
                begin
                    stall_left--;
                    pop <= 1'b0;
                end
                else if (style == 0)
                    pop <= 1'b1;
                else if (style == 1)
                    pop <= 1'($urandom_range(0, 1));
                else
                    pop <= ($urandom_range(0, 3) == 0);
            end
        end
    end

    initial
    begin
        burst_left    = 0;
        bytes_taken   = 0;
        silent_now    = 1'b0;
        hold_requests = 0;
        holds_done    = 0;
        rst_n     <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= CFG_SILENT;
        cfg_data  <= 7'd0;
        push      <= 1'b0;
        text_byte <= 8'd0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: silent off, initial attribute 7
        foreach (LEAD_IN[i])
            send_byte(LEAD_IN[i]);
        run_random(100);

        // dark initial attribute, with a long receiver hold-off
        drain();
        write_reg(CFG_INIT_ATTR, 7'd0);
        hold_requests++;
        run_random(90);

        // every attribute bit set
        drain();
        write_reg(CFG_INIT_ATTR, 7'h7F);
        run_random(90);

        // silent: bytes are dropped and parse state must survive
        drain();
        write_reg(CFG_SILENT, 7'd1);
        silent_now = 1'b1;
        repeat (12) random_unit();
        drain();
        write_reg(CFG_SILENT, 7'd0);
        silent_now = 1'b0;
        write_reg(CFG_INIT_ATTR, 7'($urandom_range(0, 127)));
        hold_requests++;
        run_random(100);

        drain();
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog, far above the slowest legal run
    initial
    begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
